// File: rtl/core/tthk_pkg.sv
// Shared types, constants and functions for the text to HID keystroke typer.
// No dependencies; every other file of the block but tthk_ram refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package tthk_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 64;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_CHAR   = 3'd1;
    localparam logic [2:0] OP_NUMBER = 3'd2;
    localparam logic [2:0] OP_START  = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic [7:0]  USAGE_LETTER_A = 8'h04;
    localparam logic [7:0]  USAGE_DIGIT_1  = 8'h1E;
    localparam logic [7:0]  USAGE_DIGIT_0  = 8'h27;
    localparam logic [7:0]  USAGE_SPC      = 8'h2C;
    localparam logic [15:0] DEFAULT_PERIOD = 16'd12;

    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int unsigned DIV10_SHIFT = 35;
    localparam int unsigned MAX_DIGITS  = 10;
    localparam int unsigned DIG_CNT_W   = 4;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  char_code;
        logic [31:0] number_value;
        logic [15:0] tap_period;
    } t_in_item;

    typedef struct packed {
        logic       event_valid;
        logic [7:0] usage_id;
        logic       key_pressed;
        logic       busy_res;
    } t_out_item;

    typedef struct packed {
        logic       hit;
        logic [7:0] usage;
    } t_map;

    typedef struct packed {
        logic load;
        logic clear;
        logic push_char;
        logic num_init;
        logic mul;
        logic div;
        logic push_dig;
        logic start_play;
        logic count_dec;
        logic stop;
        logic fire;
        logic respond;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       playing;
        logic       cd_gt1;
        logic       queue_done;
        logic       q_zero;
        logic       dig_last;
    } t_dp_status;

    function automatic t_map f_map_char(input logic [7:0] c);
        t_map m;
        m.hit   = 1'b0;
        m.usage = 8'h00;
        if (c >= 8'h61 && c <= 8'h7A) begin
            m.hit   = 1'b1;
            m.usage = USAGE_LETTER_A + (c - 8'h61);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            m.hit   = 1'b1;
            m.usage = USAGE_LETTER_A + (c - 8'h41);
        end else if (c >= 8'h31 && c <= 8'h39) begin
            m.hit   = 1'b1;
            m.usage = USAGE_DIGIT_1 + (c - 8'h31);
        end else if (c == 8'h30) begin
            m.hit   = 1'b1;
            m.usage = USAGE_DIGIT_0;
        end else if (c == 8'h20) begin
            m.hit   = 1'b1;
            m.usage = USAGE_SPC;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tthk_ram.sv
// Generic RAM with one write port, a separate read port and a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tthk_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/tthk_dp.sv
// Datapath of the typer: usage queue, playback registers, divide-by-ten unit and result register.
// Depends on tthk_pkg and tthk_ram; driven by commands from tthk_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tthk_dp #(
    parameter int unsigned QUEUE_DEPTH = tthk_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tthk_pkg::t_in_item    i_item,
    input  wire tthk_pkg::t_dp_cmd     i_cmd,
    output tthk_pkg::t_dp_status       o_status,
    output logic                       o_res_valid,
    output tthk_pkg::t_out_item        o_result
);

    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned NDIG   = tthk_pkg::MAX_DIGITS;
    localparam int unsigned DCW    = tthk_pkg::DIG_CNT_W;

    tthk_pkg::t_in_item r_item;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_play;
    logic               r_key_down;
    logic [15:0]        r_period;
    logic [15:0]        r_countdown;
    logic               r_playing;
    logic [31:0]        r_work;
    logic [63:0]        r_prod;
    logic [3:0]         r_digs [NDIG];
    logic [DCW-1:0]     r_dig_cnt;
    logic               r_ev;
    logic [7:0]         r_usage;
    logic               r_press;
    logic               r_strobe;
    tthk_pkg::t_out_item r_out;

    logic [31:0]        n_quot;
    logic [3:0]         n_rem;
    tthk_pkg::t_map     n_char_map;
    tthk_pkg::t_map     n_dig_map;
    logic               n_push;
    logic [7:0]         n_push_usage;
    logic               n_we;
    logic [7:0]         n_rdata;

    assign n_quot = 32'(r_prod >> tthk_pkg::DIV10_SHIFT);
    assign n_rem  = 4'(r_work - ((n_quot << 3) + (n_quot << 1)));

    assign n_char_map   = tthk_pkg::f_map_char(r_item.char_code);
    assign n_dig_map    = tthk_pkg::f_map_char(8'h30 + {4'h0, r_digs[0]});
    assign n_push       = (i_cmd.push_char && n_char_map.hit) || i_cmd.push_dig;
    assign n_push_usage = i_cmd.push_dig ? n_dig_map.usage : n_char_map.usage;
    assign n_we         = n_push && (r_fill < CNT_W'(QUEUE_DEPTH));

    tthk_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (n_push_usage),
        .i_raddr (r_play[ADDR_W-1:0]),
        .o_rdata (n_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_play      <= '0;
            r_key_down  <= 1'b0;
            r_period    <= tthk_pkg::DEFAULT_PERIOD;
            r_countdown <= '0;
            r_playing   <= 1'b0;
            r_dig_cnt   <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= i_cmd.respond;
            if (i_cmd.load) begin
                r_item  <= i_item;
                r_ev    <= 1'b0;
                r_usage <= 8'h00;
                r_press <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_fill     <= '0;
                r_play     <= '0;
                r_key_down <= 1'b0;
            end
            if (n_we) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.num_init) begin
                r_work    <= r_item.number_value;
                r_dig_cnt <= '0;
            end
            if (i_cmd.mul) begin
                r_prod <= 64'(r_work) * 64'(tthk_pkg::DIV10_RECIP);
            end
            if (i_cmd.div) begin
                r_work    <= n_quot;
                r_dig_cnt <= r_dig_cnt + 1'b1;
                r_digs[0] <= n_rem;
                for (int i = 1; i < NDIG; i++) begin
                    r_digs[i] <= r_digs[i-1];
                end
            end
            if (i_cmd.push_dig) begin
                r_dig_cnt <= r_dig_cnt - 1'b1;
                for (int i = 0; i < NDIG - 1; i++) begin
                    r_digs[i] <= r_digs[i+1];
                end
            end
            if (i_cmd.start_play && (r_fill != '0)) begin
                r_period    <= (r_item.tap_period != 16'd0) ? r_item.tap_period
                                                            : tthk_pkg::DEFAULT_PERIOD;
                r_countdown <= 16'd1;
                r_playing   <= 1'b1;
            end
            if (i_cmd.count_dec) begin
                r_countdown <= r_countdown - 16'd1;
            end
            if (i_cmd.stop) begin
                r_fill      <= '0;
                r_play      <= '0;
                r_playing   <= 1'b0;
                r_countdown <= '0;
            end
            if (i_cmd.fire) begin
                r_ev        <= 1'b1;
                r_usage     <= n_rdata;
                r_press     <= !r_key_down;
                r_key_down  <= !r_key_down;
                r_countdown <= r_period;
                if (r_key_down) begin
                    r_play <= r_play + 1'b1;
                end
            end
            if (i_cmd.respond) begin
                r_out.event_valid <= r_ev;
                r_out.usage_id    <= r_usage;
                r_out.key_pressed <= r_press;
                r_out.busy_res    <= (r_fill != '0);
            end
        end
    end

    assign o_status.op         = r_item.op;
    assign o_status.playing    = r_playing;
    assign o_status.cd_gt1     = (r_countdown > 16'd1);
    assign o_status.queue_done = (r_play >= r_fill);
    assign o_status.q_zero     = (n_quot == 32'd0);
    assign o_status.dig_last   = (r_dig_cnt == DCW'(1));

    assign o_res_valid = r_strobe;
    assign o_result    = r_out;

endmodule

`default_nettype wire

// File: rtl/core/tthk_ctrl.sv
// Controller of the typer: sequences each item through the datapath.
// Depends on tthk_pkg; commands tthk_dp.
`timescale 1ns / 1ps
`default_nettype none

module tthk_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire tthk_pkg::t_dp_status i_status,
    output logic                      busy,
    output tthk_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_PUSH,
        S_FIRE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_status.op)
                    tthk_pkg::OP_CLEAR:  o_cmd.clear = 1'b1;
                    tthk_pkg::OP_CHAR:   o_cmd.push_char = 1'b1;
                    tthk_pkg::OP_NUMBER: begin
                        o_cmd.num_init = 1'b1;
                        n_state        = S_MUL;
                    end
                    tthk_pkg::OP_START:  o_cmd.start_play = 1'b1;
                    tthk_pkg::OP_TICK: begin
                        if (i_status.playing) begin
                            if (i_status.cd_gt1) begin
                                o_cmd.count_dec = 1'b1;
                            end else if (i_status.queue_done) begin
                                o_cmd.stop = 1'b1;
                            end else begin
                                n_state = S_FIRE;
                            end
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = i_status.q_zero ? S_PUSH : S_MUL;
            end
            S_PUSH: begin
                o_cmd.push_dig = 1'b1;
                if (i_status.dig_last) begin
                    n_state = S_DONE;
                end
            end
            S_FIRE: begin
                o_cmd.fire = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                o_cmd.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/text_to_hid_keystroke_typer.sv
// Top level of the text to HID keystroke typer.
// Depends on tthk_pkg, tthk_ctrl, tthk_dp and tthk_ram.
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low, and each item gives exactly one result,
// shown on o_result for a single cycle while o_res_valid is high; the receiver must take it then.
// Clear, character, start and tick items that cause no key event pass through the decode and done
// states only; a tick that emits a key event also passes through a fire state, as the queue memory has a
// registered read. A number item of d decimal digits, at most 10, passes once per digit through the
// shared divide-by-ten unit (a reciprocal multiply, then the quotient and remainder), and the
// digits then enter the queue through its single write port one per cycle. The queue memory
// needs no clearing pass after reset.
module text_to_hid_keystroke_typer #(
    parameter int unsigned QUEUE_DEPTH = tthk_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire tthk_pkg::t_in_item  i_item,
    output logic                     busy,
    output logic                     o_res_valid,
    output tthk_pkg::t_out_item      o_result
);

    tthk_pkg::t_dp_cmd    w_cmd;
    tthk_pkg::t_dp_status w_status;

    tthk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .busy     (busy),
        .o_cmd    (w_cmd)
    );

    tthk_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a transfer");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result shown while an item is still in work");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held for more than one cycle");

    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_result.event_valid) |->
            (o_result.usage_id == 8'h00 && !o_result.key_pressed))
        else $error("result without key event carries event fields");

endmodule

`default_nettype wire

// File: dv/tthk_keystroke_checker.sv
// Checker for the text to HID keystroke typer: predicts every result and compares it.
// Depends on tthk_pkg for the item types, op codes and usage constants.
`timescale 1ns / 1ps

module tthk_keystroke_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_busy,
    input  wire tthk_pkg::t_in_item  i_item,
    input  wire logic                i_res_valid,
    input  wire tthk_pkg::t_out_item i_result,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_results,
    output int                       o_events
);

    localparam int DEPTH = tthk_pkg::QUEUE_DEPTH_DEFAULT;

    logic [7:0]  usage_mem [DEPTH];
    logic [6:0]  fill_cnt;
    logic [6:0]  play_pos;
    logic        key_held;
    logic        armed;
    logic [15:0] reload_ms;
    logic [15:0] ms_left;

    tthk_pkg::t_out_item keystroke_expect_q[$];
    int fails;
    int results_seen;
    int events_seen;

    function automatic logic [8:0] ascii_to_usage(input logic [7:0] c);
        logic [7:0] up;
        up = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
        if (up >= 8'h41 && up <= 8'h5A)
            return {1'b1, 8'(tthk_pkg::USAGE_LETTER_A + (up - 8'h41))};
        if (up >= 8'h31 && up <= 8'h39)
            return {1'b1, 8'(tthk_pkg::USAGE_DIGIT_1 + (up - 8'h31))};
        if (up == 8'h30)
            return {1'b1, tthk_pkg::USAGE_DIGIT_0};
        if (up == 8'h20)
            return {1'b1, tthk_pkg::USAGE_SPC};
        return 9'h000;
    endfunction

    task automatic queue_usage(input logic [8:0] mapped);
        if (mapped[8] && fill_cnt < DEPTH) begin
            usage_mem[fill_cnt[5:0]] = mapped[7:0];
            fill_cnt = fill_cnt + 7'd1;
        end
    endtask

    task automatic queue_decimal(input logic [31:0] value);
        logic [3:0]  digit [10];
        logic [31:0] rest;
        int          cnt;
        rest = value;
        cnt = 0;
        do begin
            digit[cnt] = 4'(rest % 10);
            rest = rest / 10;
            cnt++;
        end while (rest != 0);
        for (int k = cnt - 1; k >= 0; k--) begin
            queue_usage(ascii_to_usage(8'h30 + 8'(digit[k])));
        end
    endtask

    task automatic predict_keystroke(input tthk_pkg::t_in_item it,
                                     output tthk_pkg::t_out_item r);
        r = '0;
        case (it.op)
            tthk_pkg::OP_CLEAR: begin
                fill_cnt = '0;
                play_pos = '0;
                key_held = 1'b0;
            end
            tthk_pkg::OP_CHAR: begin
                queue_usage(ascii_to_usage(it.char_code));
            end
            tthk_pkg::OP_NUMBER: begin
                queue_decimal(it.number_value);
            end
            tthk_pkg::OP_START: begin
                if (fill_cnt != 0) begin
                    reload_ms = (it.tap_period != 0) ? it.tap_period : tthk_pkg::DEFAULT_PERIOD;
                    ms_left = 16'd1;
                    armed = 1'b1;
                end
            end
            tthk_pkg::OP_TICK: begin
                if (armed) begin
                    if (ms_left > 1) begin
                        ms_left = ms_left - 16'd1;
                    end else if (play_pos >= fill_cnt) begin
                        fill_cnt = '0;
                        play_pos = '0;
                        armed = 1'b0;
                        ms_left = '0;
                    end else begin
                        r.event_valid = 1'b1;
                        r.usage_id = usage_mem[play_pos[5:0]];
                        r.key_pressed = !key_held;
                        if (key_held)
                            play_pos = play_pos + 7'd1;
                        key_held = !key_held;
                        ms_left = reload_ms;
                    end
                end
            end
            default: begin
            end
        endcase
        r.busy_res = (fill_cnt != 0);
    endtask

    always @(posedge i_clk) begin : monitor
        tthk_pkg::t_out_item want;
        tthk_pkg::t_out_item fresh;
        logic                differs;
        if (!i_rst_n) begin
            fill_cnt = '0;
            play_pos = '0;
            key_held = 1'b0;
            armed = 1'b0;
            reload_ms = tthk_pkg::DEFAULT_PERIOD;
            ms_left = '0;
            keystroke_expect_q.delete();
        end else begin
            if (i_res_valid) begin
                results_seen++;
                if (i_result.event_valid)
                    events_seen++;
                if (keystroke_expect_q.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result transfer with nothing expected: ev=%0b usage=%02h",
                                 $time, i_result.event_valid, i_result.usage_id);
                    fails++;
                end else begin
                    want = keystroke_expect_q.pop_front();
                    differs = (want.event_valid !== i_result.event_valid) ||
                              (want.usage_id    !== i_result.usage_id) ||
                              (want.key_pressed !== i_result.key_pressed) ||
                              (want.busy_res    !== i_result.busy_res);
                    if (differs) begin
                        if (fails < 10) begin
                            $display("%0t: mismatch, expected ev=%0b usage=%02h press=%0b busy=%0b",
                                     $time, want.event_valid, want.usage_id,
                                     want.key_pressed, want.busy_res);
                            $display("%0t: mismatch, actual   ev=%0b usage=%02h press=%0b busy=%0b",
                                     $time, i_result.event_valid, i_result.usage_id,
                                     i_result.key_pressed, i_result.busy_res);
                        end
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_keystroke(i_item, fresh);
                keystroke_expect_q.push_back(fresh);
            end
        end
        o_fail_count <= fails;
        o_pending <= keystroke_expect_q.size();
        o_results <= results_seen;
        o_events <= events_seen;
    end

endmodule

// File: dv/text_to_hid_keystroke_typer_test.sv
// Top of the testbench for the text to HID keystroke typer: clock, reset, stimulus, verdict.
// Depends on tthk_pkg, text_to_hid_keystroke_typer and tthk_keystroke_checker.
`timescale 1ns / 1ps

module text_to_hid_keystroke_typer_test;

    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 250;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    tthk_pkg::t_in_item  i_item;
    logic                busy;
    logic                o_res_valid;
    tthk_pkg::t_out_item o_result;

    int fail_count;
    int pending;
    int results_seen;
    int events_seen;

    int items_sent;
    int directed_count;
    int burst_left;
    bit steady_flow;
    int idle_cycles;

    text_to_hid_keystroke_typer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    tthk_keystroke_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_res_valid  (o_res_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_events     (events_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [7:0] code,
                             input logic [31:0] num, input logic [15:0] tap);
        tthk_pkg::t_in_item it;
        int gap;
        it.op = op;
        it.char_code = code;
        it.number_value = num;
        it.tap_period = tap;
        if (!steady_flow) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
                repeat (gap) begin
                    @(negedge i_clk);
                    start <= 1'b0;
                end
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(tthk_pkg::OP_TICK, 8'($urandom), $urandom, 16'($urandom));
    endtask

    task automatic type_random_phrase();
        int          keys;
        int          words;
        int          pick;
        int          period;
        int          taps;
        logic [31:0] val;
        logic [15:0] tap;
        bit          flood;
        keys = 0;
        flood = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 2) == 0)
            send_item(tthk_pkg::OP_CLEAR, 8'($urandom), $urandom, 16'($urandom));
        if (flood) begin
            repeat (7) send_item(tthk_pkg::OP_NUMBER, 8'($urandom), $urandom | 32'h4000_0000,
                                 16'($urandom));
            keys = 64;
        end else begin
            words = $urandom_range(1, 6);
            repeat (words) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    pick = $urandom_range(0, 62);
                    if (pick < 26)
                        send_item(tthk_pkg::OP_CHAR, 8'h61 + 8'(pick), $urandom, 16'($urandom));
                    else if (pick < 52)
                        send_item(tthk_pkg::OP_CHAR, 8'h41 + 8'(pick - 26), $urandom,
                                  16'($urandom));
                    else if (pick < 62)
                        send_item(tthk_pkg::OP_CHAR, 8'h30 + 8'(pick - 52), $urandom,
                                  16'($urandom));
                    else
                        send_item(tthk_pkg::OP_CHAR, 8'h20, $urandom, 16'($urandom));
                    keys++;
                end else if (pick < 15) begin
                    send_item(tthk_pkg::OP_CHAR, 8'($urandom), $urandom, 16'($urandom));
                    keys++;
                end else begin
                    val = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 999);
                    send_item(tthk_pkg::OP_NUMBER, 8'($urandom), val, 16'($urandom));
                    do begin
                        keys++;
                        val = val / 10;
                    end while (val != 0);
                end
            end
            if (keys > 64)
                keys = 64;
        end
        pick = $urandom_range(0, 19);
        if (flood)
            tap = 16'd1;
        else if (pick < 14)
            tap = 16'($urandom_range(1, 3));
        else if (pick < 17)
            tap = 16'd0;
        else if (pick < 19)
            tap = 16'($urandom_range(4, 20));
        else
            tap = 16'($urandom_range(0, 65535));
        period = (tap == 0) ? 12 : tap;
        send_item(tthk_pkg::OP_START, 8'($urandom), $urandom, tap);
        taps = (2 * keys + 1) * period + $urandom_range(0, 3);
        if (taps > 200)
            taps = 200;
        repeat (taps) begin
            if ($urandom_range(0, 29) == 0) begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0: send_item(tthk_pkg::OP_CLEAR, 8'($urandom), $urandom, 16'($urandom));
                    1: send_item(tthk_pkg::OP_CHAR, 8'h61 + 8'($urandom_range(0, 25)),
                                 $urandom, 16'($urandom));
                    2: send_item(tthk_pkg::OP_START, 8'($urandom), $urandom,
                                 16'($urandom_range(1, 3)));
                    default: send_item(OP_SPARE_5 + 3'($urandom_range(0, 2)),
                                       8'($urandom), $urandom, 16'($urandom));
                endcase
            end else begin
                send_item(tthk_pkg::OP_TICK, 8'($urandom), $urandom, 16'($urandom));
            end
        end
    endtask

    initial begin
        int  random_goal;
        bit  drained_mid;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        items_sent = 0;
        burst_left = 0;
        steady_flow = 1'b0;
        drained_mid = 1'b0;
        idle_cycles = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(tthk_pkg::OP_TICK, 8'h00, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_START, 8'h00, 32'h0, 16'd7);
        send_item(tthk_pkg::OP_CLEAR, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_SPARE_5, 8'h41, 32'h0, 16'h0);
        send_item(OP_SPARE_6, 8'h41, 32'h0, 16'h0);
        send_item(OP_SPARE_7, 8'h41, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h61, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h5A, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h30, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h39, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h20, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h40, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h00, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'hFF, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h80, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_NUMBER, 8'h00, 32'd0, 16'h0);
        send_item(tthk_pkg::OP_NUMBER, 8'h00, 32'hFFFF_FFFF, 16'h0);
        send_item(tthk_pkg::OP_NUMBER, 8'h00, 32'd1_000_000_000, 16'h0);
        // Overfill the queue so that the later digits and the next character are dropped.
        repeat (4) send_item(tthk_pkg::OP_NUMBER, 8'h00, 32'hFFFF_FFFF, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h71, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_START, 8'h00, 32'h0, 16'd0);
        send_ticks(13);
        send_item(tthk_pkg::OP_START, 8'h00, 32'h0, 16'hFFFF);
        send_ticks(4);
        send_item(tthk_pkg::OP_START, 8'h00, 32'h0, 16'd1);
        send_ticks(130);
        // Clearing while playback is armed: first with the queue left empty, then refilled.
        send_item(tthk_pkg::OP_CHAR, 8'h78, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_START, 8'h00, 32'h0, 16'd2);
        send_ticks(1);
        send_item(tthk_pkg::OP_CLEAR, 8'h00, 32'h0, 16'h0);
        send_ticks(3);
        send_item(tthk_pkg::OP_CHAR, 8'h79, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_START, 8'h00, 32'h0, 16'd2);
        send_ticks(1);
        send_item(tthk_pkg::OP_CLEAR, 8'h00, 32'h0, 16'h0);
        send_item(tthk_pkg::OP_CHAR, 8'h63, 32'h0, 16'h0);
        send_ticks(6);
        directed_count = items_sent;
        wait_drained();

        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal) begin
            if (!drained_mid && items_sent > random_goal - 200) begin
                wait_drained();
                drained_mid = 1'b1;
                steady_flow = 1'b1;
            end
            if (steady_flow && items_sent > random_goal - 120)
                steady_flow = 1'b0;
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_item(3'($urandom_range(0, 7)), 8'($urandom), $urandom,
                              16'($urandom));
            end else begin
                type_random_phrase();
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d items (%0d directed) and checked %0d results, %0d of them key events.",
                 items_sent, directed_count, results_seen, events_seen);
        $display("Covered character mapping, decimal numbers, queue overflow and paced playback.");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
